@@ rtl/core/scc_pkg.sv @@
// Shared types and constants of the sector cache clock controller.
// No dependencies; used by scc_ctrl and the top level.
`default_nettype none

package scc_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_HIT,
        ST_MISS,
        ST_SWEEP,
        ST_SCAN,
        ST_SCAN_END
    } t_state;

    localparam logic [2:0] OP_READ     = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_PREFETCH = 3'd2;
    localparam logic [2:0] OP_FLUSH    = 3'd3;
    localparam logic [2:0] OP_CLEAN    = 3'd4;

    localparam int unsigned REG_SECTOR_LIMIT = 0;
    localparam int unsigned LIMIT_RESET      = 13104;

endpackage

`default_nettype wire

@@ rtl/core/sector_cache_clock_controller_core.sv @@
// Top level of the sector cache clock controller: register port and glue.
// Depends on scc_pkg, scc_tagram and scc_ctrl.
`default_nettype none

// Usage:
// A request (i_operation, i_sector) is taken when start is high and busy is
// low. Every result word is shown for one cycle with o_strobe; the word
// with o_last closes the request. The receiver cannot stall the block.
// Read, write, prefetch: one word. A hit shows once the lookup scan reaches
// its slot; a miss with a free slot once the scan has read every slot; when
// every slot is taken the clock sweep follows the scan. Out-of-range sectors
// and undefined operations answer in the next cycle.
// Flush, clean: one word per dirty slot in ascending order, or one word
// without write-back when no slot is dirty; the last follows the full scan.
// The scans step through the entry RAM, one read per cycle; the next
// request is taken in the cycle that shows the final word.
// After reset a clearing pass writes all ENTRIES slots, one per cycle,
// with busy high; register writes are taken throughout.
// sector_limit sits at byte address 0 of the register port.
module sector_cache_clock_controller_core #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 24,
    localparam int SLOT_W     = $clog2(ENTRIES),
    localparam int LIMIT_W    = SECTOR_BITS + 1,
    localparam int DATA_W     = (LIMIT_W > 32) ? 64 : 32,
    localparam int ADDR_W     = (DATA_W == 64) ? 4 : 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    input  wire logic                   start,
    input  wire logic [2:0]             i_operation,
    input  wire logic [SECTOR_BITS-1:0] i_sector,
    output logic                        busy,
    output logic                        o_strobe,
    output logic                        o_hit,
    output logic [SLOT_W-1:0]           o_slot,
    output logic                        o_writeback,
    output logic [SECTOR_BITS-1:0]      o_writeback_sector,
    output logic                        o_fill,
    output logic                        o_error,
    output logic                        o_last
);

    localparam int ENT_W = SECTOR_BITS + 3;

    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic               sel_limit;
    logic               wr_cfg;
    logic [SLOT_W-1:0]  rd_addr, wr_addr;
    logic [ENT_W-1:0]   rd_data, wr_data;
    logic               wr_en;

    assign sel_limit = (paddr[ADDR_W-1] == 1'(scc_pkg::REG_SECTOR_LIMIT));
    assign wr_cfg    = psel && penable && pwrite && sel_limit;
    assign n_limit   = wr_cfg ? pwdata[LIMIT_W-1:0] : r_limit;
    assign prdata    = sel_limit ? DATA_W'(r_limit) : '0;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(scc_pkg::LIMIT_RESET);
        end else begin
            r_limit <= n_limit;
        end
    end

    scc_tagram #(
        .ENTRIES (ENTRIES),
        .WIDTH   (ENT_W)
    ) u_tagram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    scc_ctrl #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_operation        (i_operation),
        .i_sector           (i_sector),
        .i_limit            (r_limit),
        .o_busy             (busy),
        .o_rd_addr          (rd_addr),
        .i_rd_data          (rd_data),
        .o_wr_en            (wr_en),
        .o_wr_addr          (wr_addr),
        .o_wr_data          (wr_data),
        .o_strobe           (o_strobe),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_writeback        (o_writeback),
        .o_writeback_sector (o_writeback_sector),
        .o_fill             (o_fill),
        .o_error            (o_error),
        .o_last             (o_last)
    );

`ifndef SYNTH
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error |-> o_last && !o_hit && !o_writeback && !o_fill)
        else $error("error word carries other flags");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_hit |-> !o_writeback && !o_fill && !o_error)
        else $error("hit word asks for write-back or fill");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final word shown while still busy");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("intermediate word shown while idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/scc_tagram.sv @@
// Entry store: one write port, one read port, registered read data.
// Holds valid, dirty, reference bits and tag of each slot. No dependencies.
`default_nettype none

module scc_tagram #(
    parameter int ENTRIES = 64,
    parameter int WIDTH   = 27
) (
    input  wire logic                       i_clk,
    input  wire logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]           o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data
);

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/scc_ctrl.sv @@
// Sequencer of the sector cache: lookup scan, clock sweep, flush/clean scan, clearing pass after reset.
// Depends on scc_pkg; drives the scc_tagram ports.
`default_nettype none

module scc_ctrl #(
    parameter int ENTRIES     = 64,
    parameter int SECTOR_BITS = 24,
    localparam int SLOT_W     = $clog2(ENTRIES),
    localparam int ENT_W      = SECTOR_BITS + 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [2:0]             i_operation,
    input  wire logic [SECTOR_BITS-1:0] i_sector,
    input  wire logic [SECTOR_BITS:0]   i_limit,
    output logic                        o_busy,
    output logic [SLOT_W-1:0]           o_rd_addr,
    input  wire logic [ENT_W-1:0]       i_rd_data,
    output logic                        o_wr_en,
    output logic [SLOT_W-1:0]           o_wr_addr,
    output logic [ENT_W-1:0]            o_wr_data,
    output logic                        o_strobe,
    output logic                        o_hit,
    output logic [SLOT_W-1:0]           o_slot,
    output logic                        o_writeback,
    output logic [SECTOR_BITS-1:0]      o_writeback_sector,
    output logic                        o_fill,
    output logic                        o_error,
    output logic                        o_last
);

    localparam int V_POS = SECTOR_BITS + 2;
    localparam int D_POS = SECTOR_BITS + 1;
    localparam int R_POS = SECTOR_BITS;
    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(ENTRIES - 1);

    scc_pkg::t_state r_state, n_state;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic [SLOT_W-1:0]      r_hand, n_hand;
    logic [2:0]             r_op, n_op;
    logic [SECTOR_BITS-1:0] r_sec, n_sec;
    logic                   r_found_free, n_found_free;
    logic [SLOT_W-1:0]      r_free, n_free;
    logic [SLOT_W-1:0]      r_tgt, n_tgt;
    logic [ENT_W-1:0]       r_ent, n_ent;
    logic                   r_pend, n_pend;
    logic [SLOT_W-1:0]      r_pend_slot, n_pend_slot;
    logic [SECTOR_BITS-1:0] r_pend_tag, n_pend_tag;

    logic                   r_strobe, n_strobe;
    logic                   r_hit, n_hit;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic                   r_wb, n_wb;
    logic [SECTOR_BITS-1:0] r_wbs, n_wbs;
    logic                   r_fill, n_fill;
    logic                   r_err, n_err;
    logic                   r_last, n_last;

    logic [SLOT_W-1:0]      idx_next;
    logic                   rd_valid, rd_dirty, rd_ref, rd_match;
    logic [SECTOR_BITS-1:0] rd_tag;
    logic                   is_write, is_pref, is_flush;
    logic                   in_lookup, in_scan, in_range;
    logic [ENT_W-1:0]       new_ent;

    assign idx_next  = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
    assign rd_valid  = i_rd_data[V_POS];
    assign rd_dirty  = i_rd_data[D_POS];
    assign rd_ref    = i_rd_data[R_POS];
    assign rd_tag    = i_rd_data[SECTOR_BITS-1:0];
    assign rd_match  = rd_valid && (rd_tag == r_sec);
    assign is_write  = (r_op == scc_pkg::OP_WRITE);
    assign is_pref   = (r_op == scc_pkg::OP_PREFETCH);
    assign is_flush  = (r_op == scc_pkg::OP_FLUSH);
    assign in_lookup = (i_operation <= scc_pkg::OP_PREFETCH);
    assign in_scan   = (i_operation == scc_pkg::OP_FLUSH) ||
                       (i_operation == scc_pkg::OP_CLEAN);
    assign in_range  = ({1'b0, i_sector} < i_limit);
    assign new_ent   = {1'b1, is_write, !is_pref, r_sec};

    always_comb begin
        n_state = r_state;
        case (r_state)
            scc_pkg::ST_INIT: begin
                if (r_idx == IDX_LAST) n_state = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_IDLE: begin
                if (i_start && in_lookup && in_range) begin
                    n_state = scc_pkg::ST_LOOK;
                end else if (i_start && in_scan) begin
                    n_state = scc_pkg::ST_SCAN;
                end
            end
            scc_pkg::ST_LOOK: begin
                if (rd_match) begin
                    n_state = scc_pkg::ST_HIT;
                end else if (r_idx == IDX_LAST) begin
                    n_state = scc_pkg::ST_MISS;
                end
            end
            scc_pkg::ST_HIT: n_state = scc_pkg::ST_IDLE;
            scc_pkg::ST_MISS: begin
                n_state = r_found_free ? scc_pkg::ST_IDLE : scc_pkg::ST_SWEEP;
            end
            scc_pkg::ST_SWEEP: begin
                if (!rd_ref) n_state = scc_pkg::ST_IDLE;
            end
            scc_pkg::ST_SCAN: begin
                if (r_idx == IDX_LAST) n_state = scc_pkg::ST_SCAN_END;
            end
            scc_pkg::ST_SCAN_END: n_state = scc_pkg::ST_IDLE;
            default: n_state = scc_pkg::ST_IDLE;
        endcase
    end

    // in the scan and sweep states reads run one slot ahead of the slot being written back
    always_comb begin
        n_idx        = r_idx;
        n_hand       = r_hand;
        n_op         = r_op;
        n_sec        = r_sec;
        n_found_free = r_found_free;
        n_free       = r_free;
        n_tgt        = r_tgt;
        n_ent        = r_ent;
        n_pend       = r_pend;
        n_pend_slot  = r_pend_slot;
        n_pend_tag   = r_pend_tag;
        n_strobe     = 1'b0;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_wb         = r_wb;
        n_wbs        = r_wbs;
        n_fill       = r_fill;
        n_err        = r_err;
        n_last       = r_last;
        o_rd_addr    = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx;
        o_wr_data    = '0;
        case (r_state)
            scc_pkg::ST_INIT: begin
                o_wr_en = 1'b1;
                n_idx   = idx_next;
            end
            scc_pkg::ST_IDLE: begin
                n_idx        = '0;
                n_found_free = 1'b0;
                n_pend       = 1'b0;
                if (i_start) begin
                    n_op  = i_operation;
                    n_sec = i_sector;
                    if ((in_lookup && !in_range) || (!in_lookup && !in_scan)) begin
                        n_strobe = 1'b1;
                        n_hit    = 1'b0;
                        n_slot   = '0;
                        n_wb     = 1'b0;
                        n_wbs    = '0;
                        n_fill   = 1'b0;
                        n_err    = in_lookup;
                        n_last   = 1'b1;
                    end
                end
            end
            scc_pkg::ST_LOOK: begin
                o_rd_addr = idx_next;
                n_idx     = idx_next;
                if (rd_match) begin
                    n_tgt = r_idx;
                    n_ent = i_rd_data;
                end else if (!rd_valid && !r_found_free) begin
                    n_found_free = 1'b1;
                    n_free       = r_idx;
                end
            end
            scc_pkg::ST_HIT: begin
                o_wr_en          = 1'b1;
                o_wr_addr        = r_tgt;
                o_wr_data        = r_ent;
                o_wr_data[D_POS] = r_ent[D_POS] | is_write;
                o_wr_data[R_POS] = r_ent[R_POS] | !is_pref;
                n_strobe = 1'b1;
                n_hit    = 1'b1;
                n_slot   = r_tgt;
                n_wb     = 1'b0;
                n_wbs    = '0;
                n_fill   = 1'b0;
                n_err    = 1'b0;
                n_last   = 1'b1;
            end
            scc_pkg::ST_MISS: begin
                if (r_found_free) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_free;
                    o_wr_data = new_ent;
                    n_strobe  = 1'b1;
                    n_hit     = 1'b0;
                    n_slot    = r_free;
                    n_wb      = 1'b0;
                    n_wbs     = '0;
                    n_fill    = !is_write;
                    n_err     = 1'b0;
                    n_last    = 1'b1;
                end else begin
                    o_rd_addr = r_hand;
                    n_idx     = r_hand;
                end
            end
            scc_pkg::ST_SWEEP: begin
                o_wr_en = 1'b1;
                if (rd_ref) begin
                    o_wr_data        = i_rd_data;
                    o_wr_data[R_POS] = 1'b0;
                    o_rd_addr        = idx_next;
                    n_idx            = idx_next;
                end else begin
                    o_wr_data = new_ent;
                    n_hand    = idx_next;
                    n_strobe  = 1'b1;
                    n_hit     = 1'b0;
                    n_slot    = r_idx;
                    n_wb      = rd_dirty;
                    n_wbs     = rd_dirty ? rd_tag : '0;
                    n_fill    = !is_write;
                    n_err     = 1'b0;
                    n_last    = 1'b1;
                end
            end
            scc_pkg::ST_SCAN: begin
                o_rd_addr = idx_next;
                n_idx     = idx_next;
                o_wr_en   = 1'b1;
                if (!is_flush) begin
                    o_wr_data        = i_rd_data;
                    o_wr_data[D_POS] = 1'b0;
                end
                if (rd_valid && rd_dirty) begin
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_hit    = 1'b0;
                        n_slot   = r_pend_slot;
                        n_wb     = 1'b1;
                        n_wbs    = r_pend_tag;
                        n_fill   = 1'b0;
                        n_err    = 1'b0;
                        n_last   = 1'b0;
                    end
                    n_pend      = 1'b1;
                    n_pend_slot = r_idx;
                    n_pend_tag  = rd_tag;
                end
            end
            scc_pkg::ST_SCAN_END: begin
                n_strobe = 1'b1;
                n_hit    = 1'b0;
                n_slot   = r_pend ? r_pend_slot : '0;
                n_wb     = r_pend;
                n_wbs    = r_pend ? r_pend_tag : '0;
                n_fill   = 1'b0;
                n_err    = 1'b0;
                n_last   = 1'b1;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scc_pkg::ST_INIT;
            r_idx        <= '0;
            r_hand       <= '0;
            r_found_free <= 1'b0;
            r_pend       <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_hand       <= n_hand;
            r_found_free <= n_found_free;
            r_pend       <= n_pend;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_sec       <= n_sec;
        r_free      <= n_free;
        r_tgt       <= n_tgt;
        r_ent       <= n_ent;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        r_hit       <= n_hit;
        r_slot      <= n_slot;
        r_wb        <= n_wb;
        r_wbs       <= n_wbs;
        r_fill      <= n_fill;
        r_err       <= n_err;
        r_last      <= n_last;
    end

    assign o_busy             = (r_state != scc_pkg::ST_IDLE);
    assign o_strobe           = r_strobe;
    assign o_hit              = r_hit;
    assign o_slot             = r_slot;
    assign o_writeback        = r_wb;
    assign o_writeback_sector = r_wbs;
    assign o_fill             = r_fill;
    assign o_error            = r_err;
    assign o_last             = r_last;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for sector_cache_clock_controller_core: random and directed sector requests
// checked word by word against a slot tracker kept in step with every accepted request.
// Depends on scc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int ENTRIES        = 64;
    localparam int SECTOR_BITS    = 24;
    localparam int SLOT_W         = 6;
    localparam int APB_ADDR_W     = 3;
    localparam int OP_CODE_MAX    = 7;
    localparam int POOL_MAX       = 96;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                   hit;
        logic [SLOT_W-1:0]      slot;
        logic                   wb;
        logic [SECTOR_BITS-1:0] wb_sector;
        logic                   fill;
        logic                   err;
        logic                   last;
    } t_cache_word;

    class slot_tracker;
        bit                     valid [ENTRIES];
        bit                     dirty [ENTRIES];
        bit                     used  [ENTRIES];
        logic [SECTOR_BITS-1:0] tag   [ENTRIES];
        int unsigned            hand;
        logic [SECTOR_BITS:0]   limit;
        t_cache_word            pending [$];
        int                     errors;

        function new();
            limit  = (SECTOR_BITS + 1)'(scc_pkg::LIMIT_RESET);
            hand   = 0;
            errors = 0;
        endfunction

        function void set_limit(logic [SECTOR_BITS:0] value);
            limit = value;
        endfunction

        function int pending_count();
            return pending.size();
        endfunction

        // lowest free slot, else clock sweep to first unreferenced entry
        function int unsigned pick_victim(output bit wb, output logic [SECTOR_BITS-1:0] wbs);
            int unsigned idx;
            wb  = 1'b0;
            wbs = '0;
            for (int i = 0; i < ENTRIES; i++)
                if (!valid[i])
                    return i;
            idx = hand;
            for (int i = 0; i < ENTRIES + 1; i++) begin
                if (!used[idx])
                    break;
                used[idx] = 1'b0;
                idx = (idx + 1) % ENTRIES;
            end
            hand = (idx + 1) % ENTRIES;
            if (dirty[idx]) begin
                wb  = 1'b1;
                wbs = tag[idx];
            end
            valid[idx] = 1'b0;
            dirty[idx] = 1'b0;
            used[idx]  = 1'b0;
            return idx;
        endfunction

        function void take_request(logic [2:0] op, logic [SECTOR_BITS-1:0] sec);
            t_cache_word            w;
            int unsigned            s;
            bit                     wb;
            logic [SECTOR_BITS-1:0] wbs;
            int                     top;
            w = '0;
            w.last = 1'b1;
            if (op == scc_pkg::OP_READ || op == scc_pkg::OP_WRITE ||
                op == scc_pkg::OP_PREFETCH) begin
                if ({1'b0, sec} >= limit) begin
                    w.err = 1'b1;
                    pending.push_back(w);
                    return;
                end
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid[i] && tag[i] == sec) begin
                        if (op != scc_pkg::OP_PREFETCH)
                            used[i] = 1'b1;
                        if (op == scc_pkg::OP_WRITE)
                            dirty[i] = 1'b1;
                        w.hit  = 1'b1;
                        w.slot = SLOT_W'(i);
                        pending.push_back(w);
                        return;
                    end
                end
                s = pick_victim(wb, wbs);
                valid[s] = 1'b1;
                tag[s]   = sec;
                dirty[s] = (op == scc_pkg::OP_WRITE);
                used[s]  = (op != scc_pkg::OP_PREFETCH);
                w.slot      = SLOT_W'(s);
                w.wb        = wb;
                w.wb_sector = wbs;
                w.fill      = (op != scc_pkg::OP_WRITE);
                pending.push_back(w);
            end else if (op == scc_pkg::OP_FLUSH || op == scc_pkg::OP_CLEAN) begin
                top = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (valid[i] && dirty[i])
                        top = i;
                if (top < 0)
                    pending.push_back(w);
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid[i] && dirty[i]) begin
                        w = '0;
                        w.slot      = SLOT_W'(i);
                        w.wb        = 1'b1;
                        w.wb_sector = tag[i];
                        w.last      = (i == top);
                        pending.push_back(w);
                    end
                    dirty[i] = 1'b0;
                    if (op == scc_pkg::OP_FLUSH) begin
                        valid[i] = 1'b0;
                        used[i]  = 1'b0;
                    end
                end
            end else begin
                pending.push_back(w);
            end
        endfunction

        function bit same(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_word(t_cache_word got);
            t_cache_word want;
            bit          ok;
            if (pending.size() == 0) begin
                $display("%0t: word with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            ok = same("hit", want.hit, got.hit)
               & same("slot", want.slot, got.slot)
               & same("writeback", want.wb, got.wb)
               & same("writeback_sector", want.wb_sector, got.wb_sector)
               & same("fill", want.fill, got.fill)
               & same("error", want.err, got.err)
               & same("last", want.last, got.last);
            if (!ok)
                errors++;
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   start;
    logic [2:0]             i_operation;
    logic [SECTOR_BITS-1:0] i_sector;
    logic                   busy;
    logic                   o_strobe;
    logic                   o_hit;
    logic [SLOT_W-1:0]      o_slot;
    logic                   o_writeback;
    logic [SECTOR_BITS-1:0] o_writeback_sector;
    logic                   o_fill;
    logic                   o_error;
    logic                   o_last;

    slot_tracker sb = new();
    int          idle_cycles = 0;

    sector_cache_clock_controller_core #(
        .ENTRIES     (ENTRIES),
        .SECTOR_BITS (SECTOR_BITS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .i_operation        (i_operation),
        .i_sector           (i_sector),
        .busy               (busy),
        .o_strobe           (o_strobe),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_writeback        (o_writeback),
        .o_writeback_sector (o_writeback_sector),
        .o_fill             (o_fill),
        .o_error            (o_error),
        .o_last             (o_last)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_word({o_hit, o_slot, o_writeback, o_writeback_sector,
                           o_fill, o_error, o_last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d words outstanding", $time, sb.pending_count());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(input int unsigned index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == scc_pkg::REG_SECTOR_LIMIT)
            sb.set_limit(value[SECTOR_BITS:0]);
    endtask

    task automatic send_request(input logic [2:0] op, input logic [SECTOR_BITS-1:0] sec);
        start       <= 1'b1;
        i_operation <= op;
        i_sector    <= sec;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.take_request(op, sec);
    endtask

    task automatic pause_requests(input int cycles);
        start       <= 1'b0;
        i_operation <= 3'($urandom);
        i_sector    <= SECTOR_BITS'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending_count() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // a pool_size above ENTRIES gives a working set larger than the cache, which forces clock sweeps
    task automatic run_random(input int count, input int pool_size, input bit with_gaps);
        logic [SECTOR_BITS-1:0] pool [POOL_MAX];
        int unsigned            span;
        int unsigned            pick;
        logic [2:0]             op;
        logic [SECTOR_BITS-1:0] sec;
        span = sb.limit;
        for (int k = 0; k < POOL_MAX; k++)
            pool[k] = SECTOR_BITS'($urandom % span);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = scc_pkg::OP_READ;
            else if (pick < 66)
                op = scc_pkg::OP_WRITE;
            else if (pick < 87)
                op = scc_pkg::OP_PREFETCH;
            else if (pick < 89)
                op = scc_pkg::OP_FLUSH;
            else if (pick < 95)
                op = scc_pkg::OP_CLEAN;
            else
                op = 3'($urandom_range(int'(scc_pkg::OP_CLEAN) + 1, OP_CODE_MAX));
            pick = $urandom_range(0, 99);
            if (pick < 84)
                sec = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 92 && span < (1 << SECTOR_BITS))
                sec = SECTOR_BITS'(span + $urandom % ((1 << SECTOR_BITS) - span));
            else
                sec = SECTOR_BITS'($urandom);
            if (with_gaps && $urandom_range(0, 3) == 0)
                pause_requests($urandom_range(1, 16));
            send_request(op, sec);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        start       <= 1'b0;
        i_operation <= scc_pkg::OP_READ;
        i_sector    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit in force
        send_request(scc_pkg::OP_READ, 24'd0);
        send_request(scc_pkg::OP_WRITE, 24'd0);
        send_request(scc_pkg::OP_PREFETCH, 24'd13103);
        send_request(scc_pkg::OP_READ, 24'd13103);
        send_request(scc_pkg::OP_WRITE, 24'd5);
        send_request(scc_pkg::OP_PREFETCH, 24'd5);
        send_request(scc_pkg::OP_READ, 24'd13104);
        send_request(scc_pkg::OP_WRITE, '1);
        send_request(scc_pkg::OP_PREFETCH, 24'd13104);
        for (int op = int'(scc_pkg::OP_CLEAN) + 1; op <= OP_CODE_MAX; op++)
            send_request(3'(op), 24'hA5A5A5);
        send_request(scc_pkg::OP_CLEAN, 24'h5A5A5A);
        send_request(scc_pkg::OP_CLEAN, 24'd0);
        send_request(scc_pkg::OP_WRITE, 24'd7);
        send_request(scc_pkg::OP_READ, 24'd1);
        send_request(scc_pkg::OP_FLUSH, 24'd0);
        send_request(scc_pkg::OP_FLUSH, '1);
        send_request(scc_pkg::OP_READ, 24'd7);
        pause_requests(3);
        send_request(scc_pkg::OP_WRITE, 24'd1);
        run_random(110, 80, 1'b1);

        wait_drained();
        write_reg(scc_pkg::REG_SECTOR_LIMIT, 32'h0100_0000);
        send_request(scc_pkg::OP_READ, '1);
        send_request(scc_pkg::OP_WRITE, 24'h800000);
        run_random(110, 72, 1'b1);

        wait_drained();
        write_reg(scc_pkg::REG_SECTOR_LIMIT, 32'd1);
        send_request(scc_pkg::OP_READ, 24'd0);
        send_request(scc_pkg::OP_READ, 24'd1);
        run_random(30, 8, 1'b1);

        wait_drained();
        write_reg(scc_pkg::REG_SECTOR_LIMIT, 32'($urandom_range(2, 1 << SECTOR_BITS)));
        run_random(90, 48, 1'b1);

        wait_drained();
        write_reg(scc_pkg::REG_SECTOR_LIMIT, 32'(scc_pkg::LIMIT_RESET));
        run_random(70, 80, 1'b0);

        start <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (2 * ENTRIES + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sector_cache_clock_controller_core.f @@
rtl/core/scc_pkg.sv
rtl/core/scc_tagram.sv
rtl/core/scc_ctrl.sv
rtl/core/sector_cache_clock_controller_core.sv
sim/testbench.sv
